// ----- rtl/cau_pkg.sv -----
// Package for the complex arithmetic unit: word widths, opcodes, the cell
// payload type and the saturation helper.
// No dependencies.
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int PROD_W  = 2 * DATA_WIDTH;          // full product
    localparam int SUM_W   = PROD_W + 1;              // sum of two products
    localparam int REM_W   = PROD_W + FRAC_BITS;      // scaled dividend
    localparam int QB      = DATA_WIDTH + 1;          // quotient bits kept
    localparam int DSH_W   = PROD_W + QB - 1;         // shifted divisor
    localparam int SQ_W    = PROD_W + 1;              // root accumulator
    localparam int N_CELLS = QB;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MAG = 3'd4;

    typedef struct packed {
        logic [2:0]              op;
        logic                    dz;
        logic                    big_re;
        logic                    big_im;
        logic                    neg_re;
        logic                    neg_im;
        logic signed [SUM_W-1:0] pass_re;
        logic signed [SUM_W-1:0] pass_im;
        logic [REM_W-1:0]        r_re;
        logic [REM_W-1:0]        r_im;
        logic [QB-1:0]           q_re;
        logic [QB-1:0]           q_im;
        logic [DSH_W-1:0]        d_sh;
        logic [PROD_W-1:0]       sq_n;
        logic [SQ_W-1:0]         sq_res;
        logic [SQ_W-1:0]         sq_bit;
    } cell_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] val;
        logic                  ovf;
    } sat_t;

    function automatic sat_t sat_word(input logic signed [SUM_W-1:0] x);
        sat_t r;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((64'(1) << (DATA_WIDTH - 1)) - 64'(1));
        lo = -hi - SUM_W'(1);
        if (x > hi)
        begin
            r.val = hi[DATA_WIDTH-1:0];
            r.ovf = 1'b1;
        end
        else if (x < lo)
        begin
            r.val = lo[DATA_WIDTH-1:0];
            r.ovf = 1'b1;
        end
        else
        begin
            r.val = x[DATA_WIDTH-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- rtl/cau_if.sv -----
// Stream interfaces for the request and result transactions.
// Depends on cau_pkg.
interface cau_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [2:0]                           op;
    logic signed [cau_pkg::DATA_WIDTH-1:0] a_re;
    logic signed [cau_pkg::DATA_WIDTH-1:0] a_im;
    logic signed [cau_pkg::DATA_WIDTH-1:0] b_re;
    logic signed [cau_pkg::DATA_WIDTH-1:0] b_im;
    modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, op, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cau_pkg::DATA_WIDTH-1:0] res_re;
    logic signed [cau_pkg::DATA_WIDTH-1:0] res_im;
    logic                                 div_zero;
    logic                                 overflow;
    modport source (output valid, res_re, res_im, div_zero, overflow, input ready);
    modport sink   (input valid, res_re, res_im, div_zero, overflow, output ready);
endinterface

// ----- rtl/complex_arithmetic_unit_core.sv -----
// Complex arithmetic unit, top level: front end, chain of divide/root
// cells and the saturating output register.
// Depends on cau_pkg, cau_if, cau_front and cau_cell.

// Complex ALU on signed Q16.16 operands: add, subtract, multiply, divide
// and magnitude of a. It accepts one transaction per cycle when not
// stalled and returns results in order: four front stages (operand
// register, 32x32 products, sums, sign/scale preparation), 33 chain cells
// that each retire one quotient bit of both divide lanes and one root
// digit, and the output register. The whole pipe advances together, so a
// stall on the result side holds every stage and removes ready.
// A zero divisor gives zero parts with div_zero set; products and
// quotients truncate toward zero and saturate with the overflow flag.
module complex_arithmetic_unit_core (
    input  logic      clk,
    input  logic      rst_n,
    cau_req_if.sink   req,
    cau_rsp_if.source rsp
);
    import cau_pkg::*;

    logic adv;

    logic  cv [N_CELLS+1];
    cell_t cd [N_CELLS+1];

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] res_re_reg, res_im_reg;
    logic                  div_zero_reg, overflow_reg;

    logic signed [SUM_W-1:0] cand_re, cand_im;
    logic                    dz_out;
    sat_t                    s_re, s_im;

    // the pipe moves whenever the output register is empty or being drained
    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = adv;

    cau_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (req.valid),
        .in_op      (req.op),
        .in_a_re    (req.a_re),
        .in_a_im    (req.a_im),
        .in_b_re    (req.b_re),
        .in_b_im    (req.b_im),
        .head_valid (cv[0]),
        .head       (cd[0])
    );

    // each cell halves the divisor and quarters the root bit
    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        cau_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .prev_valid (cv[i]),
            .prev       (cd[i]),
            .nxt_valid  (cv[i+1]),
            .nxt        (cd[i+1])
        );
    end

    // pick the full-precision result for the opcode, then saturate
    always_comb
    begin
        cell_t c;
        logic signed [SUM_W-1:0] big_v;
        logic signed [SUM_W-1:0] q_re, q_im;
        c      = cd[N_CELLS];
        big_v  = SUM_W'(1) <<< QB;
        q_re   = SUM_W'(c.q_re);
        q_im   = SUM_W'(c.q_im);
        dz_out = 1'b0;
        case (c.op)
            OP_ADD, OP_SUB, OP_MUL:
            begin
                cand_re = c.pass_re;
                cand_im = c.pass_im;
            end
            OP_DIV:
            begin
                if (c.dz)
                begin
                    // zero divisor: zero parts, no overflow
                    dz_out  = 1'b1;
                    cand_re = '0;
                    cand_im = '0;
                end
                else
                begin
                    if (c.big_re)
                        cand_re = c.neg_re ? -big_v : big_v;
                    else
                        cand_re = c.neg_re ? -q_re : q_re;
                    if (c.big_im)
                        cand_im = c.neg_im ? -big_v : big_v;
                    else
                        cand_im = c.neg_im ? -q_im : q_im;
                end
            end
            OP_MAG:
            begin
                cand_re = SUM_W'(c.sq_res);
                cand_im = '0;
            end
            default:
            begin
                cand_re = '0;
                cand_im = '0;
            end
        endcase
        s_re = sat_word(cand_re);
        s_im = sat_word(cand_im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= cv[N_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_re_reg   <= s_re.val;
            res_im_reg   <= s_im.val;
            div_zero_reg <= dz_out;
            overflow_reg <= s_re.ovf | s_im.ovf;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.res_re   = res_re_reg;
    assign rsp.res_im   = res_im_reg;
    assign rsp.div_zero = div_zero_reg;
    assign rsp.overflow = overflow_reg;

`ifndef SYNTHESIS
    // a zero-divisor transaction carries zero parts and no overflow
    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.div_zero |->
            rsp.res_re == '0 && rsp.res_im == '0 && !rsp.overflow)
        else $error("div_zero result not clean");

    // a held result blocks new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !req.ready)
        else $error("request taken while result stalled");

    // a stall freezes the tail of the chain
    a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> $stable(cv[N_CELLS]))
        else $error("chain moved during stall");
`endif

endmodule

// ----- rtl/cau_front.sv -----
// Front end: operand register, products, sums and preparation of the
// first cell's payload.  Depends on cau_pkg.
module cau_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [2:0]                    in_op,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_a_re,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_a_im,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_b_re,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_b_im,
    output logic                          head_valid,
    output cau_pkg::cell_t                head
);
    import cau_pkg::*;

    logic [3:0] v_reg;

    // stage 1
    logic [2:0]                   op1_reg;
    logic signed [DATA_WIDTH-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    // stage 2
    logic [2:0]                   op2_reg;
    logic signed [DATA_WIDTH-1:0] ar2_reg, ai2_reg, br2_reg, bi2_reg;
    logic signed [PROD_W-1:0]     arbr_reg, aibi_reg, arbi_reg, aibr_reg;
    logic signed [PROD_W-1:0]     brbr_reg, bibi_reg, arar_reg, aiai_reg;
    // stage 3
    logic [2:0]                   op3_reg;
    logic signed [SUM_W-1:0]      w_re_reg, w_im_reg;
    logic [PROD_W-1:0]            d3_reg, nsq3_reg;
    // stage 4
    cell_t                        head_reg;

    logic signed [SUM_W-1:0] w_re_next, w_im_next;
    cell_t                   head_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_comb
    begin
        case (op2_reg)
            OP_ADD:
            begin
                w_re_next = SUM_W'(ar2_reg) + SUM_W'(br2_reg);
                w_im_next = SUM_W'(ai2_reg) + SUM_W'(bi2_reg);
            end
            OP_SUB:
            begin
                w_re_next = SUM_W'(ar2_reg) - SUM_W'(br2_reg);
                w_im_next = SUM_W'(ai2_reg) - SUM_W'(bi2_reg);
            end
            OP_MUL:
            begin
                w_re_next = SUM_W'(arbr_reg) - SUM_W'(aibi_reg);
                w_im_next = SUM_W'(arbi_reg) + SUM_W'(aibr_reg);
            end
            OP_DIV:
            begin
                w_re_next = SUM_W'(arbr_reg) + SUM_W'(aibi_reg);
                w_im_next = SUM_W'(aibr_reg) - SUM_W'(arbi_reg);
            end
            default:
            begin
                w_re_next = '0;
                w_im_next = '0;
            end
        endcase
    end

    // sign and magnitude split, scaled dividend, quotient range check
    always_comb
    begin
        logic [SUM_W-1:0]  abs_re, abs_im, sh_re, sh_im;
        logic [REM_W-1:0]  m_re, m_im;
        logic [PROD_W+QB-1:0] d_big;
        abs_re = w_re_reg[SUM_W-1] ? -w_re_reg : w_re_reg;
        abs_im = w_im_reg[SUM_W-1] ? -w_im_reg : w_im_reg;
        sh_re  = abs_re >> FRAC_BITS;
        sh_im  = abs_im >> FRAC_BITS;
        m_re   = {abs_re[PROD_W-1:0], {FRAC_BITS{1'b0}}};
        m_im   = {abs_im[PROD_W-1:0], {FRAC_BITS{1'b0}}};
        d_big  = {d3_reg, {QB{1'b0}}};

        head_next.op     = op3_reg;
        head_next.dz     = (op3_reg == OP_DIV) && (d3_reg == '0);
        head_next.neg_re = w_re_reg[SUM_W-1];
        head_next.neg_im = w_im_reg[SUM_W-1];
        head_next.big_re = {{(PROD_W+QB-REM_W){1'b0}}, m_re} >= d_big;
        head_next.big_im = {{(PROD_W+QB-REM_W){1'b0}}, m_im} >= d_big;
        if (op3_reg == OP_MUL)
        begin
            head_next.pass_re = w_re_reg[SUM_W-1] ? -sh_re : sh_re;
            head_next.pass_im = w_im_reg[SUM_W-1] ? -sh_im : sh_im;
        end
        else
        begin
            head_next.pass_re = w_re_reg;
            head_next.pass_im = w_im_reg;
        end
        head_next.r_re   = m_re;
        head_next.r_im   = m_im;
        head_next.q_re   = '0;
        head_next.q_im   = '0;
        head_next.d_sh   = {d3_reg, {(QB-1){1'b0}}};
        head_next.sq_n   = nsq3_reg;
        head_next.sq_res = '0;
        head_next.sq_bit = {1'b1, {PROD_W{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg  <= in_op;
            ar1_reg  <= in_a_re;
            ai1_reg  <= in_a_im;
            br1_reg  <= in_b_re;
            bi1_reg  <= in_b_im;

            op2_reg  <= op1_reg;
            ar2_reg  <= ar1_reg;
            ai2_reg  <= ai1_reg;
            br2_reg  <= br1_reg;
            bi2_reg  <= bi1_reg;
            arbr_reg <= ar1_reg * br1_reg;
            aibi_reg <= ai1_reg * bi1_reg;
            arbi_reg <= ar1_reg * bi1_reg;
            aibr_reg <= ai1_reg * br1_reg;
            brbr_reg <= br1_reg * br1_reg;
            bibi_reg <= bi1_reg * bi1_reg;
            arar_reg <= ar1_reg * ar1_reg;
            aiai_reg <= ai1_reg * ai1_reg;

            op3_reg  <= op2_reg;
            w_re_reg <= w_re_next;
            w_im_reg <= w_im_next;
            d3_reg   <= brbr_reg + bibi_reg;
            nsq3_reg <= arar_reg + aiai_reg;

            head_reg <= head_next;
        end
    end

    assign head_valid = v_reg[3];
    assign head       = head_reg;

endmodule

// ----- rtl/cau_cell.sv -----
// One cell of the chain: a restoring divide step for both quotients and
// one digit of the integer square root.  Depends on cau_pkg.
module cau_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           prev_valid,
    input  cau_pkg::cell_t prev,
    output logic           nxt_valid,
    output cau_pkg::cell_t nxt
);
    import cau_pkg::*;

    logic  valid_reg;
    cell_t data_reg;
    cell_t data_next;

    always_comb
    begin
        logic ge_re, ge_im, take;
        logic [SQ_W-1:0] t;
        data_next = prev;
        ge_re = {{(DSH_W-REM_W){1'b0}}, prev.r_re} >= prev.d_sh;
        ge_im = {{(DSH_W-REM_W){1'b0}}, prev.r_im} >= prev.d_sh;
        if (ge_re)
            data_next.r_re = prev.r_re - prev.d_sh[REM_W-1:0];
        if (ge_im)
            data_next.r_im = prev.r_im - prev.d_sh[REM_W-1:0];
        data_next.q_re = {prev.q_re[QB-2:0], ge_re};
        data_next.q_im = {prev.q_im[QB-2:0], ge_im};
        data_next.d_sh = prev.d_sh >> 1;

        t    = prev.sq_res + prev.sq_bit;
        take = {1'b0, prev.sq_n} >= t;
        if (take)
        begin
            data_next.sq_n   = prev.sq_n - t[PROD_W-1:0];
            data_next.sq_res = (prev.sq_res >> 1) + prev.sq_bit;
        end
        else
            data_next.sq_res = prev.sq_res >> 1;
        data_next.sq_bit = prev.sq_bit >> 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= prev_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign nxt_valid = valid_reg;
    assign nxt       = data_reg;

endmodule

// ----- bench/cau_tb_if.sv -----
// Testbench note: the stream interfaces come from rtl/cau_if.sv.
// This file holds the shared transaction types for the bench.
// Depends on cau_pkg.
`timescale 1ns / 100ps

package cau_tb_pkg;
    import cau_pkg::*;

    typedef struct packed {
        logic [2:0]                   op;
        logic signed [DATA_WIDTH-1:0] a_re;
        logic signed [DATA_WIDTH-1:0] a_im;
        logic signed [DATA_WIDTH-1:0] b_re;
        logic signed [DATA_WIDTH-1:0] b_im;
    } cau_req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_re;
        logic signed [DATA_WIDTH-1:0] res_im;
        logic                         div_zero;
        logic                         overflow;
    } cau_rsp_t;
endpackage

// ----- bench/tb.sv -----
// Testbench for complex_arithmetic_unit_core: directed and random requests,
// a bit-exact result predictor and an in-order result scoreboard.
// Depends on cau_pkg, cau_tb_pkg and the RTL interfaces.
`timescale 1ns / 100ps

module tb;
    import cau_pkg::*;
    import cau_tb_pkg::*;

    localparam int LATENCY   = 38;
    localparam int MAX_CYCLE = 200000;
    localparam logic signed [DATA_WIDTH-1:0] WMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] WMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic clk;
    logic rst_n;

    cau_req_if req ();
    cau_rsp_if rsp ();

    complex_arithmetic_unit_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    cau_req_t pending_reqs[$];
    cau_rsp_t expected_rsps[$];
    int       errors;
    int       cycle_count;
    bit       stim_done;
    bit       hold_until_drained;   // sender pause request
    int       hold_off_cycles;      // receiver long stall request

    // Saturate a wide signed value to one word; flags clipping.
    function automatic logic signed [DATA_WIDTH-1:0] clip_word(
        input logic signed [255:0] x, inout logic ovf);
        if (x > 256'(signed'(WMAX)))
        begin
            ovf = 1'b1;
            return WMAX;
        end
        if (x < 256'(signed'(WMIN)))
        begin
            ovf = 1'b1;
            return WMIN;
        end
        return x[DATA_WIDTH-1:0];
    endfunction

    // Signed division truncating toward zero (SV '/' already does so).
    function automatic logic signed [255:0] trunc_div(
        input logic signed [255:0] n, input logic signed [255:0] d);
        return n / d;
    endfunction

    function automatic logic [255:0] floor_sqrt(input logic [255:0] n);
        logic [255:0] root;
        logic [255:0] bitv;
        logic [255:0] t;
        root = '0;
        bitv = 256'd1 << 254;
        while (bitv != 0 && bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            t = root + bitv;
            if (n >= t)
            begin
                n = n - t;
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Expected result for one request transaction.
    function automatic cau_rsp_t complex_result(input cau_req_t r);
        cau_rsp_t o;
        logic signed [255:0] ar, ai, br, bi, re, im, den;
        logic ovf;
        ar = r.a_re;
        ai = r.a_im;
        br = r.b_re;
        bi = r.b_im;
        re = '0;
        im = '0;
        ovf = 1'b0;
        o.div_zero = 1'b0;
        case (r.op)
            OP_ADD:
            begin
                re = ar + br;
                im = ai + bi;
            end
            OP_SUB:
            begin
                re = ar - br;
                im = ai - bi;
            end
            OP_MUL:
            begin
                re = trunc_div(ar * br - ai * bi, 256'sd1 <<< FRAC_BITS);
                im = trunc_div(ar * bi + ai * br, 256'sd1 <<< FRAC_BITS);
            end
            OP_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    o.div_zero = 1'b1;
                else
                begin
                    re = trunc_div((ar * br + ai * bi) <<< FRAC_BITS, den);
                    im = trunc_div((ai * br - ar * bi) <<< FRAC_BITS, den);
                end
            end
            OP_MAG:
                re = floor_sqrt(ar * ar + ai * ai);
            default: ;
        endcase
        o.res_re = clip_word(re, ovf);
        o.res_im = clip_word(im, ovf);
        o.overflow = ovf;
        return o;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return WMAX;
            1: return WMIN;
            2: return DATA_WIDTH'($signed($urandom_range(0, 8)) - 4);
            3: return DATA_WIDTH'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    function automatic cau_req_t make_req(input logic [2:0] op,
        input logic signed [DATA_WIDTH-1:0] ar, input logic signed [DATA_WIDTH-1:0] ai,
        input logic signed [DATA_WIDTH-1:0] br, input logic signed [DATA_WIDTH-1:0] bi);
        cau_req_t r;
        r.op = op;
        r.a_re = ar;
        r.a_im = ai;
        r.b_re = br;
        r.b_im = bi;
        return r;
    endfunction

    // Reset and stimulus. Directed corners first, then random traffic with
    // one drained pause and one long receiver hold-off in the middle.
    initial
    begin
        cau_req_t r;
        logic signed [DATA_WIDTH-1:0] one;
        errors = 0;
        stim_done = 1'b0;
        hold_until_drained = 1'b0;
        hold_off_cycles = 0;
        rst_n = 1'b0;
        one = DATA_WIDTH'(1) << FRAC_BITS;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        pending_reqs.push_back(make_req(OP_ADD, WMAX, WMIN, one, -one));
        pending_reqs.push_back(make_req(OP_ADD, WMIN, WMAX, WMIN, WMAX));
        pending_reqs.push_back(make_req(OP_SUB, WMIN, WMAX, one, -one));
        pending_reqs.push_back(make_req(OP_SUB, 0, 0, WMIN, WMIN));
        pending_reqs.push_back(make_req(OP_MUL, one, one, one, -one));
        pending_reqs.push_back(make_req(OP_MUL, WMIN, WMIN, WMIN, WMAX));
        pending_reqs.push_back(make_req(OP_MUL, -1, 1, 1, 1));
        pending_reqs.push_back(make_req(OP_MUL, WMAX, WMAX, WMAX, WMAX));
        pending_reqs.push_back(make_req(OP_DIV, one, one, 0, 0));      // zero divisor
        pending_reqs.push_back(make_req(OP_DIV, WMAX, WMIN, 1, 0));    // huge quotient
        pending_reqs.push_back(make_req(OP_DIV, -one, 3, one, one));
        pending_reqs.push_back(make_req(OP_DIV, WMIN, WMIN, WMIN, WMIN));
        pending_reqs.push_back(make_req(OP_DIV, 1, -1, WMAX, WMIN));
        pending_reqs.push_back(make_req(OP_MAG, 3, 4, 0, 0));
        pending_reqs.push_back(make_req(OP_MAG, WMIN, WMIN, 0, 0));    // saturates
        pending_reqs.push_back(make_req(OP_MAG, WMAX, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_MAG, 0, 0, WMAX, WMIN));
        pending_reqs.push_back(make_req(3'd5, WMAX, WMIN, -1, 1));     // unused opcodes
        pending_reqs.push_back(make_req(3'd6, -1, -1, -1, -1));
        pending_reqs.push_back(make_req(3'd7, 1, 2, 3, 4));

        for (int i = 0; i < 600; i++)
        begin
            if (i == 200)
            begin
                wait (pending_reqs.size() == 0);
                hold_until_drained = 1'b1;
                wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
                @(posedge clk);
                hold_until_drained = 1'b0;
            end
            if (i == 400)
                hold_off_cycles = 150;
            r = make_req(3'($urandom_range(0, 7)), rand_word(), rand_word(),
                         rand_word(), rand_word());
            if ($urandom_range(0, 9) == 0)
            begin
                r.b_re = 0;
                r.b_im = 0;
            end
            pending_reqs.push_back(r);
        end
        stim_done = 1'b1;
    end

    // Request driver: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.op    <= '0;
            req.a_re  <= '0;
            req.a_im  <= '0;
            req.b_re  <= '0;
            req.b_im  <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!req.valid || req.ready)
        begin
            // previous transaction, if any, was taken at this edge
            if (req.valid)
                void'(pending_reqs.pop_front());
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req.valid <= 1'b0;
            end
            else if (pending_reqs.size() > (req.valid ? 0 : 0) && !hold_until_drained
                     && pending_reqs.size() > 0)
            begin
                req.valid <= 1'b1;
                {req.op, req.a_re, req.a_im, req.b_re, req.b_im} <= pending_reqs[0];
                expected_rsps.push_back(complex_result(pending_reqs[0]));
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Result receiver: own stall pattern plus one long hold-off.
    int stall_phase;
    int hold_count;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready   <= 1'b0;
            stall_phase <= 0;
            hold_count  <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (hold_off_cycles > 0 && hold_count == 0)
            begin
                hold_count <= hold_off_cycles;
                hold_off_cycles = 0;
                rsp.ready <= 1'b0;
            end
            else if (hold_count > 0)
            begin
                hold_count <= hold_count - 1;
                rsp.ready <= (hold_count == 1);
            end
            else if (stall_phase[8])
                rsp.ready <= 1'b1;                   // stall-free stretch
            else
                rsp.ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        cau_rsp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.res_re !== want.res_re)
                begin
                    $error("res_re expected %0d got %0d", want.res_re, rsp.res_re);
                    errors++;
                end
                if (rsp.res_im !== want.res_im)
                begin
                    $error("res_im expected %0d got %0d", want.res_im, rsp.res_im);
                    errors++;
                end
                if (rsp.div_zero !== want.div_zero)
                begin
                    $error("div_zero expected %0b got %0b", want.div_zero, rsp.div_zero);
                    errors++;
                end
                if (rsp.overflow !== want.overflow)
                begin
                    $error("overflow expected %0b got %0b", want.overflow, rsp.overflow);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < MAX_CYCLE)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("complex_arithmetic_unit_core verification failed");
        $finish;
    end

    // End of run: wait until drained, then check for missing results and report.
    initial
    begin
        wait (stim_done);
        wait (pending_reqs.size() == 0 && !req.valid && expected_rsps.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (expected_rsps.size() != 0)
        begin
            $error("%0d results never arrived", expected_rsps.size());
            errors++;
        end
        if (errors == 0)
            $display("complex_arithmetic_unit_core verification clean");
        else
            $display("complex_arithmetic_unit_core verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cau_pkg.sv
rtl/cau_if.sv
rtl/cau_front.sv
rtl/cau_cell.sv
rtl/complex_arithmetic_unit_core.sv
bench/cau_tb_if.sv
bench/tb.sv
